// ----- src/ttcd_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package ttcd_pkg;

	localparam int unsigned SECS_W   = 32;
	localparam int unsigned DAYS_W   = 16;
	localparam int unsigned REM_W    = 17;
	localparam int unsigned YEAR_W   = 8;
	localparam int unsigned MONTH_W  = 4;
	localparam int unsigned DAY_W    = 5;
	localparam int unsigned HOUR_W   = 5;
	localparam int unsigned MINUTE_W = 6;
	localparam int unsigned WDAY_W   = 3;
	localparam int unsigned DOY_W    = 9;

	localparam logic [16:0] SECS_PER_DAY  = 17'd86400;
	localparam logic [11:0] SECS_PER_HOUR = 12'd3600;
	localparam logic [2:0]  DAYS_PER_WEEK = 3'd7;
	localparam logic [2:0]  EPOCH_WDAY    = 3'd2;

	// Days are taken as (secs >> 7) / 675 through a reciprocal; the
	// estimate is low by at most one and is fixed after the back multiply.
	localparam int unsigned DAY_PRE_SHIFT = 7;
	localparam logic [16:0] DAY_RECIP     = 17'd99420;
	localparam int unsigned DAY_SHIFT     = 26;
	localparam logic [18:0] HOUR_RECIP    = 19'd298262;
	localparam int unsigned HOUR_SHIFT    = 30;
	localparam logic [14:0] MIN_RECIP     = 15'd17477;
	localparam int unsigned MIN_SHIFT     = 20;
	localparam logic [16:0] WEEK_RECIP    = 17'd74899;
	localparam int unsigned WEEK_SHIFT    = 19;

	localparam logic [7:0] YEAR_MAX       = 8'd136;
	localparam logic [7:0] YEAR_NO_LEAP   = 8'd120;
	localparam int unsigned SPLIT_LAT     = 3;
	localparam int unsigned DATE_LAT      = YEAR_W + 3;
	localparam int unsigned CLK_LAT       = 5;
	localparam int unsigned CLK_PAD       = DATE_LAT - CLK_LAT;

	typedef struct packed {
		logic [HOUR_W-1:0]   hour;
		logic [MINUTE_W-1:0] minute;
		logic [WDAY_W-1:0]   wday;
	} clk_fields_t;

	// First day of a year, counted from the epoch. Year 2100 is the only
	// year in range that is divisible by four and not a leap year.
	function automatic logic [16:0] year_start(input logic [7:0] y);
		logic [16:0] base;
		logic [8:0]  leaps;
		base  = 17'(y) * 17'd365;
		leaps = (9'(y) + 9'd3) >> 2;
		year_start = base + 17'(leaps) - 17'(y > YEAR_NO_LEAP);
	endfunction

	function automatic logic is_leap(input logic [7:0] y);
		is_leap = (y[1:0] == 2'b00) && (y != YEAR_NO_LEAP);
	endfunction

	// First day of month m (0 is January) within its year.
	function automatic logic [DOY_W-1:0] month_start(input logic [3:0] m, input logic leap);
		logic [DOY_W-1:0] s;
		case (m)
			4'd0:    s = 9'd0;
			4'd1:    s = 9'd31;
			4'd2:    s = 9'd59;
			4'd3:    s = 9'd90;
			4'd4:    s = 9'd120;
			4'd5:    s = 9'd151;
			4'd6:    s = 9'd181;
			4'd7:    s = 9'd212;
			4'd8:    s = 9'd243;
			4'd9:    s = 9'd273;
			4'd10:   s = 9'd304;
			4'd11:   s = 9'd334;
			default: s = 9'd0;
		endcase
		month_start = s + 9'(leap && (m >= 4'd2));
	endfunction

endpackage

`default_nettype wire

// ----- src/ttcd_day_split.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ttcd_day_split
	import ttcd_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              en,
	input  wire logic              valid_in,
	input  wire logic [SECS_W-1:0] secs,
	output logic                   valid_out,
	output logic [DAYS_W-1:0]      days,
	output logic [REM_W-1:0]       rem
);

	localparam int unsigned PRE_W = SECS_W - DAY_PRE_SHIFT;

	logic                    vld_s1, vld_s2, vld_s3;
	logic [PRE_W+16:0]       est_s1;
	logic [SECS_W-1:0]       secs_s1, secs_s2;
	logic [DAYS_W-1:0]       q_s2;
	logic [DAYS_W+16:0]      back_s2;
	logic [DAYS_W-1:0]       q_est;
	logic [17:0]             diff;
	logic                    over;

	assign q_est = est_s1[DAY_SHIFT +: DAYS_W];
	assign diff  = 18'(secs_s2 - back_s2[SECS_W-1:0]);
	assign over  = diff >= 18'(SECS_PER_DAY);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= valid_in;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			est_s1  <= (PRE_W + 17)'(secs[SECS_W-1:DAY_PRE_SHIFT]) * (PRE_W + 17)'(DAY_RECIP);
			secs_s1 <= secs;
			q_s2    <= q_est;
			back_s2 <= (DAYS_W + 17)'(q_est) * (DAYS_W + 17)'(SECS_PER_DAY);
			secs_s2 <= secs_s1;
			days    <= q_s2 + DAYS_W'(over);
			rem     <= over ? REM_W'(diff - 18'(SECS_PER_DAY)) : REM_W'(diff);
		end
	end

	assign valid_out = vld_s3;

endmodule

`default_nettype wire

// ----- src/ttcd_clock.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ttcd_clock
	import ttcd_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              en,
	input  wire logic [DAYS_W-1:0] days,
	input  wire logic [REM_W-1:0]  rem,
	output clk_fields_t            fields
);

	logic [35:0]         hprod_s1;
	logic [33:0]         wprod_s1;
	logic [REM_W-1:0]    rem_s1, rem_s2;
	logic [16:0]         wnum_s1, wnum_s2;
	logic [HOUR_W-1:0]   hour_s2, hour_s3, hour_s4, hour_s5;
	logic [12:0]         wq_s2;
	logic [11:0]         mrem_s3;
	logic [WDAY_W-1:0]   wday_s3, wday_s4, wday_s5;
	logic [26:0]         mprod_s4;
	logic [MINUTE_W-1:0] minute_s5;
	logic [16:0]         wnum;
	logic [16:0]         hour_secs;
	logic [16:0]         week_days;
	clk_fields_t         pad_s [0:CLK_PAD];

	assign wnum      = 17'(days) + 17'(EPOCH_WDAY);
	assign hour_secs = 17'(hour_s2) * 17'(SECS_PER_HOUR);
	assign week_days = 17'(wq_s2) * 17'(DAYS_PER_WEEK);

	always_ff @(posedge clk) begin
		if (en) begin
			hprod_s1  <= 36'(rem) * 36'(HOUR_RECIP);
			wprod_s1  <= 34'(wnum) * 34'(WEEK_RECIP);
			rem_s1    <= rem;
			wnum_s1   <= wnum;
			hour_s2   <= hprod_s1[HOUR_SHIFT +: HOUR_W];
			wq_s2     <= wprod_s1[WEEK_SHIFT +: 13];
			rem_s2    <= rem_s1;
			wnum_s2   <= wnum_s1;
			mrem_s3   <= 12'(rem_s2 - hour_secs);
			wday_s3   <= WDAY_W'(wnum_s2 - week_days);
			hour_s3   <= hour_s2;
			mprod_s4  <= 27'(mrem_s3) * 27'(MIN_RECIP);
			hour_s4   <= hour_s3;
			wday_s4   <= wday_s3;
			minute_s5 <= mprod_s4[MIN_SHIFT +: MINUTE_W];
			hour_s5   <= hour_s4;
			wday_s5   <= wday_s4;
		end
	end

	assign pad_s[0] = '{hour: hour_s5, minute: minute_s5, wday: wday_s5};

	for (genvar k = 0; k < CLK_PAD; k++) begin : g_pad
		always_ff @(posedge clk) begin
			if (en) begin
				pad_s[k+1] <= pad_s[k];
			end
		end
	end

	assign fields = pad_s[CLK_PAD];

endmodule

`default_nettype wire

// ----- src/ttcd_date.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ttcd_date
	import ttcd_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              en,
	input  wire logic              valid_in,
	input  wire logic [DAYS_W-1:0] days,
	output logic                   valid_out,
	output logic [YEAR_W-1:0]      year_offset,
	output logic [MONTH_W-1:0]     month_number,
	output logic [DAY_W-1:0]       day_of_month
);

	logic [YEAR_W-1:0]  idx_s  [0:YEAR_W];
	logic [DAYS_W-1:0]  days_s [0:YEAR_W];
	logic               vld_s  [0:YEAR_W];

	logic               vld_s9, vld_s10, vld_s11;
	logic [DOY_W-1:0]   doy_s9, doy_s10;
	logic               leap_s9, leap_s10;
	logic [YEAR_W-1:0]  yr_s9, yr_s10;
	logic [MONTH_W-1:0] mon_s10;
	logic [MONTH_W-1:0] mon_cnt;

	assign idx_s[0]  = '0;
	assign days_s[0] = days;
	assign vld_s[0]  = valid_in;

	// Binary search over year starts, one bit of the year offset per stage.
	for (genvar k = 0; k < YEAR_W; k++) begin : g_search
		localparam logic [YEAR_W-1:0] STEP = YEAR_W'(1) << (YEAR_W - 1 - k);
		logic [YEAR_W-1:0] cand;
		logic              take;

		assign cand = idx_s[k] | STEP;
		assign take = (cand <= YEAR_MAX) && (17'(days_s[k]) >= year_start(cand));

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				idx_s[k+1]  <= take ? cand : idx_s[k];
				days_s[k+1] <= days_s[k];
			end
		end
	end

	always_comb begin
		mon_cnt = '0;
		for (int i = 1; i < 12; i++) begin
			mon_cnt = mon_cnt + MONTH_W'(doy_s9 >= month_start(MONTH_W'(i), leap_s9));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s9  <= 1'b0;
			vld_s10 <= 1'b0;
			vld_s11 <= 1'b0;
		end else if (en) begin
			vld_s9  <= vld_s[YEAR_W];
			vld_s10 <= vld_s9;
			vld_s11 <= vld_s10;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			doy_s9       <= DOY_W'(17'(days_s[YEAR_W]) - year_start(idx_s[YEAR_W]));
			leap_s9      <= is_leap(idx_s[YEAR_W]);
			yr_s9        <= idx_s[YEAR_W];
			mon_s10      <= mon_cnt;
			doy_s10      <= doy_s9;
			leap_s10     <= leap_s9;
			yr_s10       <= yr_s9;
			month_number <= mon_s10 + MONTH_W'(1);
			day_of_month <= DAY_W'(doy_s10 - month_start(mon_s10, leap_s10) + DOY_W'(1));
			year_offset  <= yr_s10;
		end
	end

	assign valid_out = vld_s11;

endmodule

`default_nettype wire

// ----- src/timestamp_to_calendar_date.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Converts a 32-bit count of seconds since 1980-01-01 00:00:00 into year offset, month, day of
// month, hour, minute and weekday (Sunday is 0); seconds within the minute are dropped. The block
// is a fully pipelined datapath that takes one item per clock, in which three stages split the
// count into days and seconds of the day by reciprocal multiplication, then eight stages search
// the year by its bits and three more resolve month and day, while the time of day and weekday
// are computed alongside. A stall at the output holds the whole pipeline, and in_ready is high
// whenever the output register is empty or taken.

module timestamp_to_calendar_date
	import ttcd_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [SECS_W-1:0] seconds_since_epoch,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic [YEAR_W-1:0]      year_offset,
	output logic [MONTH_W-1:0]     month_number,
	output logic [DAY_W-1:0]       day_of_month,
	output logic [HOUR_W-1:0]      hour_of_day,
	output logic [MINUTE_W-1:0]    minute_of_hour,
	output logic [WDAY_W-1:0]      weekday
);

	logic              en;
	logic              split_vld;
	logic [DAYS_W-1:0] split_days;
	logic [REM_W-1:0]  split_rem;
	clk_fields_t       tod;

	assign en       = out_ready || !out_valid;
	assign in_ready = en;

	ttcd_day_split u_split (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.valid_in  (in_valid),
		.secs      (seconds_since_epoch),
		.valid_out (split_vld),
		.days      (split_days),
		.rem       (split_rem)
	);

	ttcd_date u_date (
		.clk          (clk),
		.arst_n       (arst_n),
		.en           (en),
		.valid_in     (split_vld),
		.days         (split_days),
		.valid_out    (out_valid),
		.year_offset  (year_offset),
		.month_number (month_number),
		.day_of_month (day_of_month)
	);

	ttcd_clock u_clock (
		.clk    (clk),
		.en     (en),
		.days   (split_days),
		.rem    (split_rem),
		.fields (tod)
	);

	assign hour_of_day    = tod.hour;
	assign minute_of_hour = tod.minute;
	assign weekday        = tod.wday;

endmodule

`default_nettype wire

// ----- src/ttcd_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ttcd_checker
	import ttcd_pkg::*;
(
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                in_valid,
	input wire logic                in_ready,
	input wire logic [SECS_W-1:0]   seconds_since_epoch,
	input wire logic                out_valid,
	input wire logic                out_ready,
	input wire logic [YEAR_W-1:0]   year_offset,
	input wire logic [MONTH_W-1:0]  month_number,
	input wire logic [DAY_W-1:0]    day_of_month,
	input wire logic [HOUR_W-1:0]   hour_of_day,
	input wire logic [MINUTE_W-1:0] minute_of_hour,
	input wire logic [WDAY_W-1:0]   weekday
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(year_offset) && $stable(month_number)
			&& $stable(day_of_month) && $stable(hour_of_day) && $stable(minute_of_hour)
			&& $stable(weekday))
		else $error("result item changed while stalled");

	a_empty_takes: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input refused while the output register is empty");

	a_ranges: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> year_offset <= YEAR_MAX && month_number >= 4'd1 && month_number <= 4'd12
			&& day_of_month >= 5'd1 && day_of_month <= 5'd31 && hour_of_day <= 5'd23
			&& minute_of_hour <= 6'd59 && weekday <= 3'd6)
		else $error("result field out of range");

	a_short_months: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && month_number == 4'd2 |-> day_of_month <= 5'd29)
		else $error("February day out of range");

	a_no_out_from_idle: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(arst_n) ##1 1'b1 |-> !out_valid)
		else $error("result item right after reset");

endmodule

bind timestamp_to_calendar_date ttcd_checker u_ttcd_checker (
	.clk                 (clk),
	.arst_n              (arst_n),
	.in_valid            (in_valid),
	.in_ready            (in_ready),
	.seconds_since_epoch (seconds_since_epoch),
	.out_valid           (out_valid),
	.out_ready           (out_ready),
	.year_offset         (year_offset),
	.month_number        (month_number),
	.day_of_month        (day_of_month),
	.hour_of_day         (hour_of_day),
	.minute_of_hour      (minute_of_hour),
	.weekday             (weekday)
);

`default_nettype wire
